// ----- rtl/efg_pkg.sv -----
// efg_pkg: constants and codes for the endpoint forwarding gate.
// No dependencies; compiled first.

package efg_pkg;

    // Field widths fixed by the message format
    localparam int ID_W       = 24;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 3;

    // Heartbeat message ID
    localparam logic [ID_W-1:0] HEARTBEAT_ID = '0;

    // Filter list
    localparam int FILTER_SLOTS = 4;
    localparam int SLOT_W       = $clog2(FILTER_SLOTS);
    localparam logic MODE_ACCEPT_LISTED = 1'b0;
    localparam logic MODE_DROP_LISTED   = 1'b1;

    // Opcodes
    localparam logic OP_OFFERED  = 1'b0;
    localparam logic OP_RECEIVED = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_SENT        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ASLEEP_DROP = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HB_LIMITED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FILTERED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STAMPED     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ID_A        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ID_B        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ID_C        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ID_D        = 3'd7;

    // Reset value of filter_mode
    localparam logic FILTER_MODE_RESET = MODE_DROP_LISTED;

    // One result transaction
    typedef struct packed {
        logic                forward;
        logic [STATUS_W-1:0] status;
        logic                asleep;
    } result_t;

endpackage

// ----- rtl/efg_if.sv -----
// efg_if: valid/ready channel interfaces for events in and results out.
// Depends on efg_pkg.

interface efg_req_if
    import efg_pkg::*;
#(
    parameter int TIME_BITS = 32
) ();
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [ID_W-1:0]      msg_id;
    logic [TIME_BITS-1:0] now_ticks;

    modport source (output valid, output opcode, output msg_id, output now_ticks,
                    input ready);
    modport sink   (input valid, input opcode, input msg_id, input now_ticks,
                    output ready);
endinterface

interface efg_res_if
    import efg_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                forward;
    logic [STATUS_W-1:0] status;
    logic                asleep;

    modport source (output valid, output forward, output status, output asleep,
                    input ready);
    modport sink   (input valid, input forward, input status, input asleep,
                    output ready);
endinterface

// ----- rtl/endpoint_forward_gate.sv -----
// endpoint_forward_gate: sleep, heartbeat rate limit and ID filter for one endpoint.
// Depends on efg_pkg and the channel interfaces in efg_if.sv.
//
// Usage:
//   request : event transactions (opcode, msg_id, now_ticks). Opcode offered means
//             a message from another endpoint that may be forwarded here; opcode
//             received means a complete message arrived here (wakes and stamps).
//   result  : one transaction per event: forward, status, asleep (state after event).
//   cfg_*   : plain write port, register index 0..7 in the order idle limit,
//             heartbeat_interval, filter_mode, filter_count, filter_id_a..d.
//             Write only while the gate holds no event in flight.
// Pipeline: input register, then result register. Throughput: one event per cycle
//   while result is not held; the sleep/heartbeat state is updated in the same cycle
//   the event moves into the result register, so the next event sees it without a
//   bubble.
// Stall: while result is held, the input register takes at most one more transaction,
//   then stays full with request.ready low; no transaction is lost or repeated.
// Reset: all control and state cleared; filter_mode resets to drop-listed,
//   sleeping clear, no heartbeat seen yet.

module endpoint_forward_gate
    import efg_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    efg_req_if.sink                                      request,
    efg_res_if.source                                    result,
    input  logic                                         cfg_we,
    input  logic [CFG_IDX_W-1:0]                         cfg_index,
    input  logic [((TIME_BITS > ID_W) ? TIME_BITS : ID_W)-1:0] cfg_data
);

    // ---------------- configuration registers ----------------
    logic [TIME_BITS-1:0] idle_limit_reg;
    logic [TIME_BITS-1:0] heartbeat_interval_reg;
    logic                 filter_mode_reg;
    logic [COUNT_W-1:0]   filter_count_reg;
    logic [ID_W-1:0]      filter_id_reg [FILTER_SLOTS];

    // ---------------- gate state ----------------
    logic                 sleeping_reg,   sleeping_next;
    logic [TIME_BITS-1:0] last_act_reg,   last_act_next;
    logic [TIME_BITS-1:0] last_hb_reg,    last_hb_next;
    logic                 no_hb_reg,      no_hb_next;

    // ---------------- input register ----------------
    logic                 in_valid_reg;
    logic                 in_opcode_reg;
    logic [ID_W-1:0]      in_id_reg;
    logic [TIME_BITS-1:0] in_now_reg;

    // ---------------- result register ----------------
    logic                 out_valid_reg;
    result_t              out_reg, out_next;

    logic advance;   // result register can take a new transaction
    logic process;   // event in the input register is evaluated this cycle

    assign advance       = !out_valid_reg || result.ready;
    assign process       = advance && in_valid_reg;
    assign request.ready = !in_valid_reg || advance;

    assign result.valid   = out_valid_reg;
    assign result.forward = out_reg.forward;
    assign result.status  = out_reg.status;
    assign result.asleep  = out_reg.asleep;

    // ---------------- event evaluation ----------------
    logic                 is_hb;
    logic                 sleep_en;
    logic [TIME_BITS-1:0] idle_ticks;
    logic [TIME_BITS-1:0] hb_gap;
    logic                 sleep_now;
    logic                 hb_limited;
    logic [COUNT_W-1:0]   active_slots;
    logic [FILTER_SLOTS-1:0] slot_hit;
    logic                 listed;
    logic                 filtered;

    always_comb
    begin
        is_hb      = (in_id_reg == HEARTBEAT_ID);
        sleep_en   = (idle_limit_reg != '0);
        idle_ticks = in_now_reg - last_act_reg;
        hb_gap     = in_now_reg - last_hb_reg;
        sleep_now  = sleeping_reg || (idle_ticks > idle_limit_reg);
        hb_limited = (heartbeat_interval_reg != '0) && !no_hb_reg
                     && (hb_gap <= heartbeat_interval_reg);

        // counts above the slot count saturate
        active_slots = (filter_count_reg > COUNT_W'(FILTER_SLOTS))
                       ? COUNT_W'(FILTER_SLOTS) : filter_count_reg;
        for (int k = 0; k < FILTER_SLOTS; k++)
        begin
            slot_hit[k] = (COUNT_W'(k) < active_slots) && (filter_id_reg[k] == in_id_reg);
        end
        listed   = |slot_hit;
        filtered = (filter_mode_reg == MODE_ACCEPT_LISTED) ? !listed : listed;

        sleeping_next = sleeping_reg;
        last_act_next = last_act_reg;
        last_hb_next  = last_hb_reg;
        no_hb_next    = no_hb_reg;
        out_next.forward = 1'b0;
        out_next.status  = ST_SENT;

        if (in_opcode_reg == OP_RECEIVED)
        begin
            sleeping_next   = 1'b0;
            last_act_next   = in_now_reg;
            out_next.status = ST_STAMPED;
        end
        else
        begin
            if (sleep_en)
            begin
                sleeping_next = sleep_now;
            end
            if (sleep_en && sleep_now && !is_hb)
            begin
                out_next.status = ST_ASLEEP_DROP;
            end
            else if (sleep_en && sleep_now && hb_limited)
            begin
                out_next.status = ST_HB_LIMITED;
            end
            else
            begin
                if (is_hb)
                begin
                    last_hb_next = in_now_reg;
                    no_hb_next   = 1'b0;
                end
                if (filtered)
                begin
                    out_next.status = ST_FILTERED;
                end
                else
                begin
                    out_next.forward = 1'b1;
                end
            end
        end
        out_next.asleep = sleeping_next;
    end

    // ---------------- control and state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            idle_limit_reg         <= '0;
            heartbeat_interval_reg <= '0;
            filter_mode_reg        <= FILTER_MODE_RESET;
            filter_count_reg       <= '0;
            for (int k = 0; k < FILTER_SLOTS; k++)
            begin
                filter_id_reg[k] <= '0;
            end
            sleeping_reg           <= 1'b0;
            last_act_reg           <= '0;
            last_hb_reg            <= '0;
            no_hb_reg              <= 1'b1;
        end
        else
        begin
            if (request.ready)
            begin
                in_valid_reg <= request.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end

            // re-arming sleep mode on an idle limit write, as when the endpoint is opened
            if (cfg_we && cfg_index == REG_IDLE_LIMIT)
            begin
                sleeping_reg <= (cfg_data[TIME_BITS-1:0] != '0);
            end
            else if (process)
            begin
                sleeping_reg <= sleeping_next;
            end

            if (process)
            begin
                last_act_reg <= last_act_next;
                last_hb_reg  <= last_hb_next;
                no_hb_reg    <= no_hb_next;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IDLE_LIMIT:         idle_limit_reg <= cfg_data[TIME_BITS-1:0];
                    REG_HEARTBEAT_INTERVAL: heartbeat_interval_reg <= cfg_data[TIME_BITS-1:0];
                    REG_FILTER_MODE:        filter_mode_reg  <= cfg_data[0];
                    REG_FILTER_COUNT:       filter_count_reg <= cfg_data[COUNT_W-1:0];
                    REG_FILTER_ID_A, REG_FILTER_ID_B, REG_FILTER_ID_C, REG_FILTER_ID_D:
                        filter_id_reg[cfg_index[SLOT_W-1:0]] <= cfg_data[ID_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (request.ready && request.valid)
        begin
            in_opcode_reg <= request.opcode;
            in_id_reg     <= request.msg_id;
            in_now_reg    <= request.now_ticks;
        end
        if (process)
        begin
            out_reg <= out_next;
        end
    end

    // ---------------- assertions ----------------
    // a received message always reports awake and not forwarded
    a_stamp_awake: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == ST_STAMPED) |-> (!out_reg.asleep && !out_reg.forward))
        else $error("stamped result reports asleep or forwarded");

    // forwarded only with status sent
    a_fwd_sent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.forward) |-> (out_reg.status == ST_SENT))
        else $error("forwarded result with non-sent status");

    // a received event with no configuration write leaves the gate awake
    a_wake: assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_opcode_reg == OP_RECEIVED && !cfg_we) |=> !sleeping_reg)
        else $error("gate still asleep after received message");

    // sleep can only be entered while sleep mode is enabled
    a_sleep_en: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sleeping_reg) |-> (idle_limit_reg != '0))
        else $error("gate fell asleep with sleep mode disabled");

endmodule
